// ===== hw/rtl/creg_pkg.sv =====
package creg_pkg;

   localparam int LineBytesDefault = 256;
   localparam int PosWidth = 8;
   localparam int NumWidth = 8;
   localparam int StatusWidth = 9;

   localparam logic [7:0] CharColon = 8'd58;
   localparam logic [7:0] CharComma = 8'd44;
   localparam logic [7:0] CharSpace = 8'd32;
   localparam logic [7:0] CharPlus = 8'd43;
   localparam logic [7:0] CharMinus = 8'd45;
   localparam logic [7:0] CharZero = 8'd48;
   localparam logic [7:0] CharNine = 8'd57;
   localparam logic [7:0] CharTab = 8'd9;
   localparam logic [7:0] CharCr = 8'd13;
   localparam logic [NumWidth-1:0] NumMax = 8'd255;
   localparam logic [NumWidth-1:0] StatHome = 8'd1;
   localparam logic [NumWidth-1:0] StatRoam = 8'd5;

   typedef enum logic [3:0] {
      PH_COLON     = 4'd0,
      PH_FIRST     = 4'd1,
      PH_FIRST_IN  = 4'd2,
      PH_SECOND    = 4'd3,
      PH_SECOND_IN = 4'd4,
      PH_THIRD     = 4'd5,
      PH_THIRD_IN  = 4'd6,
      PH_FOURTH    = 4'd7,
      PH_DONE      = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      NUM_SPACE  = 2'd0,
      NUM_SIGN   = 2'd1,
      NUM_DIGITS = 2'd2,
      NUM_STOP   = 2'd3
   } num_mode_type;

   typedef struct packed {
      logic [NumWidth-1:0] mag;
      num_mode_type        mode;
      logic                neg;
      logic                digits;
   } num_state_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic                   parse_ok;
      logic                   registered;
      logic [StatusWidth-1:0] reg_status;
      logic                   area_present;
      logic [PosWidth-1:0]    area_offset;
      logic                   cell_present;
      logic [PosWidth-1:0]    cell_offset;
   } rsp_type;

endpackage

// ===== hw/rtl/creg_ifs.sv =====
interface creg_req_if;
   import creg_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       line_end;
   modport source (output valid, output line_byte, output line_end, input ready);
   modport sink (input valid, input line_byte, input line_end, output ready);
endinterface

interface creg_rsp_if;
   import creg_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   parse_ok;
   logic                   registered;
   logic [StatusWidth-1:0] reg_status;
   logic                   area_present;
   logic [PosWidth-1:0]    area_offset;
   logic                   cell_present;
   logic [PosWidth-1:0]    cell_offset;
   modport source (output valid, output parse_ok, output registered, output reg_status,
                   output area_present, output area_offset, output cell_present,
                   output cell_offset, input ready);
   modport sink (input valid, input parse_ok, input registered, input reg_status,
                 input area_present, input area_offset, input cell_present,
                 input cell_offset, output ready);
endinterface

// ===== hw/rtl/creg_num_dec.sv =====
module creg_num_dec
   import creg_pkg::*;
(
   input  num_state_type cur,
   input  logic          feed,
   input  logic [7:0]    char_in,
   output num_state_type nxt
);

   logic          dig;
   logic          ws;
   logic [3:0]    d;
   logic [11:0]   acc;

   assign dig = (char_in >= CharZero) && (char_in <= CharNine);
   assign ws = (char_in == CharSpace) || ((char_in >= CharTab) && (char_in <= CharCr));
   assign d = 4'(char_in - CharZero);
   assign acc = {1'b0, cur.mag, 3'b000} + {3'b000, cur.mag, 1'b0} + {8'd0, d};

   always_comb begin
      nxt = cur;
      if (feed) begin
         unique case (cur.mode)
            NUM_SPACE: begin
               if (ws) begin
                  nxt = cur;
               end else if ((char_in == CharPlus) || (char_in == CharMinus)) begin
                  nxt.neg = (char_in == CharMinus);
                  nxt.mode = NUM_SIGN;
               end else if (dig) begin
                  nxt.mag = {4'd0, d};
                  nxt.digits = 1'b1;
                  nxt.mode = NUM_DIGITS;
               end else begin
                  nxt.mode = NUM_STOP;
               end
            end
            NUM_SIGN: begin
               if (dig) begin
                  nxt.mag = {4'd0, d};
                  nxt.digits = 1'b1;
                  nxt.mode = NUM_DIGITS;
               end else begin
                  nxt.mode = NUM_STOP;
               end
            end
            NUM_DIGITS: begin
               if (dig) begin
                  nxt.mag = (acc > {4'd0, NumMax}) ? NumMax : acc[NumWidth-1:0];
               end else begin
                  nxt.mode = NUM_STOP;
               end
            end
            NUM_STOP: nxt = cur;
            default: nxt = cur;
         endcase
      end
   end

endmodule

// ===== hw/rtl/creg_scanner.sv =====
module creg_scanner
   import creg_pkg::*;
#(
   parameter int LINE_BYTES = LineBytesDefault
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output rsp_type result
);

   localparam int PosLimitInt = (LINE_BYTES - 1 < 255) ? LINE_BYTES - 1 : 255;
   localparam logic [PosWidth-1:0] PosLimit = PosLimitInt[PosWidth-1:0];

   phase_type           phase_ff, phase_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [3:0]          seen_ff, seen_in;
   logic [PosWidth-1:0] start2_ff, start2_in;
   logic [PosWidth-1:0] start3_ff, start3_in;
   logic [PosWidth-1:0] start4_ff, start4_in;
   num_state_type       num1_ff, num1_in;
   num_state_type       num2_ff, num2_in;
   num_state_type       num1_dec, num2_dec;
   logic                feed1, feed2;
   logic [7:0]          c;
   logic                is_comma;
   logic                is_space;

   assign c = item.line_byte;
   assign is_comma = (c == CharComma);
   assign is_space = (c == CharSpace);

   creg_num_dec u_num1 (.cur(num1_ff), .feed(feed1), .char_in(c), .nxt(num1_dec));
   creg_num_dec u_num2 (.cur(num2_ff), .feed(feed2), .char_in(c), .nxt(num2_dec));

   always_comb begin
      phase_in = phase_ff;
      seen_in = seen_ff;
      start2_in = start2_ff;
      start3_in = start3_ff;
      start4_in = start4_ff;
      feed1 = 1'b0;
      feed2 = 1'b0;
      unique case (phase_ff)
         PH_COLON: begin
            if (c == CharColon) phase_in = PH_FIRST;
         end
         PH_FIRST: begin
            if (!is_space) begin
               seen_in[0] = 1'b1;
               if (is_comma) begin
                  phase_in = PH_SECOND;
               end else begin
                  phase_in = PH_FIRST_IN;
                  feed1 = 1'b1;
               end
            end
         end
         PH_FIRST_IN: begin
            if (is_comma) phase_in = PH_SECOND;
            else feed1 = 1'b1;
         end
         PH_SECOND: begin
            start2_in = pos_ff;
            seen_in[1] = 1'b1;
            if (is_comma) begin
               phase_in = PH_THIRD;
            end else begin
               phase_in = PH_SECOND_IN;
               feed2 = 1'b1;
            end
         end
         PH_SECOND_IN: begin
            if (is_comma) phase_in = PH_THIRD;
            else feed2 = 1'b1;
         end
         PH_THIRD: begin
            if (!is_space) begin
               start3_in = pos_ff;
               seen_in[2] = 1'b1;
               phase_in = is_comma ? PH_FOURTH : PH_THIRD_IN;
            end
         end
         PH_THIRD_IN: begin
            if (is_comma) phase_in = PH_FOURTH;
         end
         PH_FOURTH: begin
            if (!is_space) begin
               start4_in = pos_ff;
               seen_in[3] = 1'b1;
               phase_in = PH_DONE;
            end
         end
         PH_DONE: phase_in = PH_DONE;
         default: phase_in = phase_ff;
      endcase
      num1_in = num1_dec;
      num2_in = num2_dec;
      pos_in = (pos_ff < PosLimit) ? pos_ff + 1'b1 : pos_ff;
   end

   // end of line result, taken from the updated state
   logic          f2, f3, f4;
   logic          pick2;
   num_state_type pick;
   logic          ok;

   assign f2 = seen_in[1];
   assign f3 = seen_in[2];
   assign f4 = seen_in[3];
   assign pick2 = f2 && ((!f3 && !f4) || (f3 && f4));
   assign pick = pick2 ? num2_in : num1_in;
   assign ok = (phase_in >= PH_FIRST_IN) && pick.digits;

   always_comb begin
      result = '0;
      result.reg_status = '1;
      if (ok) begin
         result.parse_ok = 1'b1;
         result.registered = !pick.neg && ((pick.mag == StatHome) || (pick.mag == StatRoam));
         result.reg_status = pick.neg ? StatusWidth'(-{1'b0, pick.mag}) : {1'b0, pick.mag};
         if (f2 && f3 && !f4) begin
            result.area_present = 1'b1;
            result.area_offset = start2_in;
            result.cell_present = 1'b1;
            result.cell_offset = start3_in;
         end else if (f3 && f4) begin
            result.area_present = 1'b1;
            result.area_offset = start3_in;
            result.cell_present = 1'b1;
            result.cell_offset = start4_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.line_end)) begin
         phase_ff <= PH_COLON;
         pos_ff <= '0;
         seen_ff <= '0;
         start2_ff <= '0;
         start3_ff <= '0;
         start4_ff <= '0;
         num1_ff <= '0;
         num2_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         seen_ff <= seen_in;
         start2_ff <= start2_in;
         start3_ff <= start3_in;
         start4_ff <= start4_in;
         num1_ff <= num1_in;
         num2_ff <= num2_in;
      end
   end

endmodule

// ===== hw/rtl/creg_registration_line_parser.sv =====
// the item holding the end mark passes the input register, and its result is then captured in the output register
// throughput: one item per cycle while the result side does not stall, set by the per-byte scanner update
// back pressure on the result side stalls both the input register and the scanner
// reset (synchronous) empties both registers and returns the scanner to its start state
module creg_registration_line_parser
   import creg_pkg::*;
#(
   parameter int LINE_BYTES = LineBytesDefault
)(
   input  logic        clock,
   input  logic        reset,
   creg_req_if.sink    req_if,
   creg_rsp_if.source  rsp_if
);

   logic    in_valid_ff;
   req_type in_item_ff;
   logic    out_valid_ff;
   rsp_type out_item_ff;
   rsp_type result;
   logic    advance;

   assign advance = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;

   creg_scanner #(.LINE_BYTES(LINE_BYTES)) u_scanner (
      .clock  (clock),
      .reset  (reset),
      .step   (advance && in_valid_ff),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_if.valid;
         out_valid_ff <= in_valid_ff && in_item_ff.line_end;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_item_ff <= '{line_byte: req_if.line_byte, line_end: req_if.line_end};
         out_item_ff <= result;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.parse_ok = out_item_ff.parse_ok;
   assign rsp_if.registered = out_item_ff.registered;
   assign rsp_if.reg_status = out_item_ff.reg_status;
   assign rsp_if.area_present = out_item_ff.area_present;
   assign rsp_if.area_offset = out_item_ff.area_offset;
   assign rsp_if.cell_present = out_item_ff.cell_present;
   assign rsp_if.cell_offset = out_item_ff.cell_offset;

endmodule

// ===== tb/sv/creg_line_checker.sv =====
`timescale 1ns / 100ps

module creg_line_checker
   import creg_pkg::*;
#(
   parameter int LINE_BYTES = LineBytesDefault
)(
   input  logic  clock,
   input  logic  reset,
   creg_req_if   req_mon,
   creg_rsp_if   rsp_mon,
   output int    mismatch_count,
   output int    lines_in_flight
);

   localparam int PosLimit = (LINE_BYTES - 1 < 255) ? LINE_BYTES - 1 : 255;

   typedef struct {
      phase_type           phase;
      logic [PosWidth-1:0] pos;
      logic [3:0]          seen;
      logic [PosWidth-1:0] start2;
      logic [PosWidth-1:0] start3;
      logic [PosWidth-1:0] start4;
      num_state_type       num1;
      num_state_type       num2;
   } line_scan_type;

   line_scan_type scan;
   rsp_type       verdict_q[$];
   int            lines_checked;

   function automatic line_scan_type fresh_scan();
      line_scan_type s;
      s.phase  = PH_COLON;
      s.pos    = '0;
      s.seen   = '0;
      s.start2 = '0;
      s.start3 = '0;
      s.start4 = '0;
      s.num1   = '0;
      s.num2   = '0;
      return s;
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return (c == CharSpace) || (c >= CharTab && c <= CharCr);
   endfunction

   function automatic num_state_type number_step(num_state_type n, logic [7:0] c);
      logic        dig;
      logic [7:0]  d;
      logic [11:0] wide;
      dig = (c >= CharZero) && (c <= CharNine);
      d = c - CharZero;
      case (n.mode)
         NUM_SPACE: begin
            if (!is_blank(c)) begin
               if (c == CharPlus || c == CharMinus) begin
                  n.neg = (c == CharMinus);
                  n.mode = NUM_SIGN;
               end else if (dig) begin
                  n.mag = d;
                  n.digits = 1'b1;
                  n.mode = NUM_DIGITS;
               end else begin
                  n.mode = NUM_STOP;
               end
            end
         end
         NUM_SIGN: begin
            if (dig) begin
               n.mag = d;
               n.digits = 1'b1;
               n.mode = NUM_DIGITS;
            end else begin
               n.mode = NUM_STOP;
            end
         end
         NUM_DIGITS: begin
            if (dig) begin
               wide = {4'b0, n.mag} * 12'd10 + {4'b0, d};
               n.mag = (wide > 12'd255) ? NumMax : wide[7:0];
            end else begin
               n.mode = NUM_STOP;
            end
         end
         default: ;
      endcase
      return n;
   endfunction

   function automatic line_scan_type scan_byte(line_scan_type s, logic [7:0] c);
      case (s.phase)
         PH_COLON: begin
            if (c == CharColon) s.phase = PH_FIRST;
         end
         PH_FIRST: begin
            if (c != CharSpace) begin
               s.seen[0] = 1'b1;
               if (c == CharComma) begin
                  s.phase = PH_SECOND;
               end else begin
                  s.phase = PH_FIRST_IN;
                  s.num1 = number_step(s.num1, c);
               end
            end
         end
         PH_FIRST_IN: begin
            if (c == CharComma) s.phase = PH_SECOND;
            else s.num1 = number_step(s.num1, c);
         end
         PH_SECOND: begin
            s.start2 = s.pos;
            s.seen[1] = 1'b1;
            if (c == CharComma) begin
               s.phase = PH_THIRD;
            end else begin
               s.phase = PH_SECOND_IN;
               s.num2 = number_step(s.num2, c);
            end
         end
         PH_SECOND_IN: begin
            if (c == CharComma) s.phase = PH_THIRD;
            else s.num2 = number_step(s.num2, c);
         end
         PH_THIRD: begin
            if (c != CharSpace) begin
               s.start3 = s.pos;
               s.seen[2] = 1'b1;
               s.phase = (c == CharComma) ? PH_FOURTH : PH_THIRD_IN;
            end
         end
         PH_THIRD_IN: begin
            if (c == CharComma) s.phase = PH_FOURTH;
         end
         PH_FOURTH: begin
            if (c != CharSpace) begin
               s.start4 = s.pos;
               s.seen[3] = 1'b1;
               s.phase = PH_DONE;
            end
         end
         default: ;
      endcase
      if (s.pos < PosLimit) s.pos = s.pos + 1'b1;
      return s;
   endfunction

   function automatic rsp_type line_verdict(line_scan_type s);
      rsp_type       r;
      num_state_type pick;
      logic          two;
      logic          three;
      logic          four;
      two = s.seen[1];
      three = s.seen[2];
      four = s.seen[3];
      pick = s.num1;
      if (two && ((!three && !four) || (three && four))) pick = s.num2;
      r = '0;
      if (s.phase < PH_FIRST_IN || !pick.digits) begin
         r.reg_status = '1;
      end else begin
         r.parse_ok = 1'b1;
         r.registered = !pick.neg && (pick.mag == StatHome || pick.mag == StatRoam);
         r.reg_status = pick.neg ? 9'd0 - {1'b0, pick.mag} : {1'b0, pick.mag};
         if (two && three && !four) begin
            r.area_present = 1'b1;
            r.area_offset = s.start2;
            r.cell_present = 1'b1;
            r.cell_offset = s.start3;
         end else if (three && four) begin
            r.area_present = 1'b1;
            r.area_offset = s.start3;
            r.cell_present = 1'b1;
            r.cell_offset = s.start4;
         end
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("line %0d: %s expected %0h got %0h", lines_checked, name, want, got);
      end
   endtask

   initial begin
      scan = fresh_scan();
      mismatch_count = 0;
      lines_in_flight = 0;
      lines_checked = 0;
   end

   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            scan = scan_byte(scan, req_mon.line_byte);
            if (req_mon.line_end) begin
               verdict_q.push_back(line_verdict(scan));
               scan = fresh_scan();
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (verdict_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: status %0h ok %0b",
                           rsp_mon.reg_status, rsp_mon.parse_ok);
            end else begin
               want = verdict_q.pop_front();
               check_field("parse_ok", 9'(want.parse_ok), 9'(rsp_mon.parse_ok));
               check_field("registered", 9'(want.registered), 9'(rsp_mon.registered));
               check_field("reg_status", want.reg_status, rsp_mon.reg_status);
               check_field("area_present", 9'(want.area_present),
                           9'(rsp_mon.area_present));
               check_field("area_offset", 9'(want.area_offset), 9'(rsp_mon.area_offset));
               check_field("cell_present", 9'(want.cell_present),
                           9'(rsp_mon.cell_present));
               check_field("cell_offset", 9'(want.cell_offset), 9'(rsp_mon.cell_offset));
            end
            lines_checked++;
         end
         lines_in_flight = verdict_q.size();
      end
   end

endmodule

// ===== tb/sv/tb_creg_registration_line_parser.sv =====
`timescale 1ns / 100ps

module tb_creg_registration_line_parser;
   import creg_pkg::*;

   localparam int LineBytes = LineBytesDefault;
   localparam int QuietLimit = 1000;
   localparam int ItemTarget = 1100;

   logic       clock;
   logic       reset;
   int         mismatch_count;
   int         lines_in_flight;
   int         quiet_cycles;
   int         stall_left;
   int         items_sent;
   int         long_lines;
   logic       steady;
   logic [7:0] line_buf[$];

   creg_req_if req_ch ();
   creg_rsp_if rsp_ch ();

   creg_registration_line_parser #(.LINE_BYTES(LineBytes)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   creg_line_checker #(.LINE_BYTES(LineBytes)) line_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .mismatch_count  (mismatch_count),
      .lines_in_flight (lines_in_flight)
   );

   always #6 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         stall_left = steady ? 0 : gap_len();
      end
   end

   task automatic send_byte(logic [7:0] b, logic e);
      int g;
      g = steady ? 0 : gap_len();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.line_byte <= b;
      req_ch.line_end <= e;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_line();
      int i;
      for (i = 0; i < line_buf.size(); i++)
         send_byte(line_buf[i], i == line_buf.size() - 1);
      items_sent += line_buf.size();
      line_buf.delete();
   endtask

   task automatic put_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic send_text(string s);
      put_text(s);
      send_line();
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      wait (lines_in_flight == 0);
      @(negedge clock);
   endtask

   function automatic logic [7:0] any_blank();
      case ($urandom_range(0, 5))
         0: return CharTab;
         1: return 8'd10;
         2: return 8'd11;
         3: return 8'd12;
         4: return CharCr;
         default: return CharSpace;
      endcase
   endfunction

   task automatic put_number();
      int r;
      int v;
      if ($urandom_range(0, 9) == 0) line_buf.push_back(any_blank());
      r = $urandom_range(0, 99);
      if (r < 10) line_buf.push_back(CharPlus);
      else if (r < 20) line_buf.push_back(CharMinus);
      r = $urandom_range(0, 99);
      if (r < 60) v = $urandom_range(0, 5);
      else if (r < 85) v = $urandom_range(0, 99);
      else v = $urandom_range(0, 99999);
      put_text($sformatf("%0d", v));
      if ($urandom_range(0, 9) == 0) put_text("x");
   endtask

   task automatic put_field();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) begin
      end else if (r < 22) begin
         repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else if (r < 32) begin
         put_text($sformatf("\"%h\"", $urandom_range(0, 65535)));
      end else begin
         put_number();
      end
   endtask

   task automatic build_line();
      int r;
      int k;
      int fields;
      logic [7:0] c;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         r = $urandom_range(0, 99);
         if (long_lines < 2 && r < 2) begin
            long_lines++;
            repeat ($urandom_range(250, 275)) put_text("A");
         end else if (r < 75) begin
            put_text("+CREG");
         end else if (r < 85) begin
            repeat ($urandom_range(1, 4)) begin
               c = 8'($urandom_range(0, 255));
               line_buf.push_back(c == CharColon ? CharSpace : c);
            end
         end
         line_buf.push_back(CharColon);
         repeat ($urandom_range(0, 2)) line_buf.push_back(CharSpace);
         r = $urandom_range(0, 99);
         if (r < 10) fields = 1;
         else if (r < 45) fields = 2;
         else if (r < 65) fields = 3;
         else if (r < 90) fields = 4;
         else fields = $urandom_range(5, 6);
         for (k = 0; k < fields; k++) begin
            if (k > 0) begin
               line_buf.push_back(CharComma);
               if ($urandom_range(0, 3) == 0)
                  repeat ($urandom_range(1, 2)) line_buf.push_back(CharSpace);
            end
            put_field();
         end
         if ($urandom_range(0, 99) < 8 && line_buf.size() > 1)
            repeat ($urandom_range(1, line_buf.size() - 1)) void'(line_buf.pop_back());
      end
   endtask

   initial begin : watchdog
      quiet_cycles = 0;
      while (quiet_cycles < QuietLimit) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      clock = 1'b0;
      reset = 1'b1;
      steady = 1'b0;
      stall_left = 0;
      items_sent = 0;
      long_lines = 0;
      req_ch.valid = 1'b0;
      req_ch.line_byte = '0;
      req_ch.line_end = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      line_buf.push_back(8'h00);
      line_buf.push_back(8'hFF);
      send_line();
      send_text(":");
      send_text(":x");
      send_text(":-999");
      send_text(":0,5,,x,y");
      send_text(":2,a,b");
      send_text(":1,-0");
      drain();

      while (items_sent < ItemTarget) begin
         steady = ($urandom_range(0, 99) < 15);
         build_line();
         send_line();
         if ($urandom_range(0, 49) == 0) drain();
      end
      req_ch.valid <= 1'b0;
      steady = 1'b0;

      wait (lines_in_flight == 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== creg_registration_line_parser.f =====
hw/rtl/creg_pkg.sv
hw/rtl/creg_ifs.sv
hw/rtl/creg_num_dec.sv
hw/rtl/creg_scanner.sv
hw/rtl/creg_registration_line_parser.sv
tb/sv/creg_line_checker.sv
tb/sv/tb_creg_registration_line_parser.sv
